/* sv/wma_pkg.sv */
// shared constants and types for the windowed moving average block
`default_nettype none

package wma_pkg;

   localparam int MAX_WINDOW  = 32;
   localparam int SLOT_W      = $clog2(MAX_WINDOW);
   localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
   localparam int SAMPLE_W    = 32;
   localparam int SUM_W       = SAMPLE_W + SLOT_W;
   localparam int WINDOW_W    = 6;
   localparam int HELD_W      = 6;
   localparam int DIV_STEP_W  = $clog2(SUM_W);
   localparam int REQ_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = SAMPLE_W + HELD_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_ACCUM,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage : wma_pkg

`default_nettype wire

/* sv/windowed_moving_average_top.sv */
// boxcar moving average over a ring memory with an iterative divider
`default_nettype none

// Boxcar moving average of signed 32-bit samples. Each request carries one sample
// (tdata) and a restart flag (tuser) that clears the history before the sample is
// taken; each request gives one response with the average (sum / samples held,
// truncated toward zero) and the number of samples held. Writing the window
// register (1..32, zero reads as 1, larger values saturate) also clears the
// history; window writes are taken only while the block is idle. Samples live in
// a 32-entry ring memory, read in ST_READ ahead of the running-sum update in
// ST_ACCUM. A response follows its request through the memory read, sum update,
// divider load, a restoring divider that retires one quotient bit per cycle, and
// a register for the result. Requests are taken one at a time; the next one is
// taken while the previous response still waits in the output register, and a
// finished result waits until that register is free.
module windowed_moving_average_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // sample[31:0]
   input  wire logic [wma_pkg::REQ_TDATA_W-1:0] req_tdata,
   // restart
   input  wire logic                            req_tuser,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // average[31:0], samples_held[37:32], zero pad above
   output logic [wma_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [wma_pkg::WINDOW_W-1:0]    csr_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready
);
   import wma_pkg::*;

   state_type                  state_ff, state_in;
   logic [WINDOW_W-1:0]        window_ff, window_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SLOT_W-1:0]          write_slot_ff, write_slot_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic                       full_ff, full_in;
   logic [SAMPLE_W-1:0]        sample_ff, sample_in;
   logic [SUM_W-1:0]           quo_ff, quo_in;
   logic [CNT_W-1:0]           rem_ff, rem_in;
   logic [DIV_STEP_W-1:0]      step_ff, step_in;
   logic                       neg_ff, neg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        avg_ff, avg_in;
   logic [HELD_W-1:0]          held_ff, held_in;

   logic [SAMPLE_W-1:0]        ring [MAX_WINDOW];
   logic [SAMPLE_W-1:0]        rd_data_ff;
   logic                       ring_we;

   logic [CNT_W-1:0]           win;
   logic [SLOT_W-1:0]          base_slot;
   logic [CNT_W-1:0]           base_fill;
   logic [CNT_W-1:0]           slot_next;
   logic signed [SUM_W-1:0]    old_term;
   logic [CNT_W:0]             trial;
   logic                       trial_ge;
   logic [SAMPLE_W-1:0]        quo_low;

   // zero and oversize window values are folded into range
   always_comb begin
      if (window_ff == '0) begin
         win = CNT_W'(1);
      end else if (int'(window_ff) > MAX_WINDOW) begin
         win = CNT_W'(MAX_WINDOW);
      end else begin
         win = CNT_W'(window_ff);
      end
   end

   // a window write wins over a request in the same cycle
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({held_ff, avg_ff});
   assign ring_we    = (state_ff == ST_ACCUM);

   always_comb begin
      base_slot = req_tuser ? '0 : write_slot_ff;
      base_fill = req_tuser ? '0 : fill_ff;
      slot_next = CNT_W'(slot_ff) + CNT_W'(1);
      old_term  = full_ff ? SUM_W'(signed'(rd_data_ff)) : '0;
      trial     = {rem_ff, quo_ff[SUM_W-1]};
      trial_ge  = (trial >= {1'b0, fill_ff});
      quo_low   = quo_ff[SAMPLE_W-1:0];
   end

   always_comb begin
      state_in      = state_ff;
      window_in     = window_ff;
      sum_in        = sum_ff;
      write_slot_in = write_slot_ff;
      fill_in       = fill_ff;
      slot_in       = slot_ff;
      full_in       = full_ff;
      sample_in     = sample_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff;
      avg_in        = avg_ff;
      held_in       = held_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               window_in     = csr_data;
               sum_in        = '0;
               write_slot_in = '0;
               fill_in       = '0;
            end else if (req_tvalid) begin
               // restart clears the history before this sample
               sum_in    = req_tuser ? '0 : sum_ff;
               fill_in   = base_fill;
               slot_in   = (CNT_W'(base_slot) >= win) ? '0 : base_slot;
               full_in   = (base_fill >= win);
               sample_in = req_tdata[SAMPLE_W-1:0];
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_in        = sum_ff - old_term + SUM_W'(signed'(sample_ff));
            fill_in       = full_ff ? fill_ff : fill_ff + CNT_W'(1);
            write_slot_in = (slot_next >= win) ? '0 : slot_next[SLOT_W-1:0];
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            neg_in   = sum_ff[SUM_W-1];
            quo_in   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
            rem_in   = '0;
            step_in  = DIV_STEP_W'(SUM_W - 1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // restoring division, one quotient bit per cycle
            rem_in = trial_ge ? CNT_W'(trial - {1'b0, fill_ff}) : trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], trial_ge};
            if (step_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff - DIV_STEP_W'(1);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               avg_in       = neg_ff ? (~quo_low + SAMPLE_W'(1)) : quo_low;
               held_in      = HELD_W'(fill_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_ff     <= WINDOW_W'(1);
         sum_ff        <= '0;
         write_slot_ff <= '0;
         fill_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_ff     <= window_in;
         sum_ff        <= sum_in;
         write_slot_ff <= write_slot_in;
         fill_ff       <= fill_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      full_ff   <= full_in;
      sample_ff <= sample_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      neg_ff    <= neg_in;
      avg_ff    <= avg_in;
      held_ff   <= held_in;
   end

   // sample ring, registered read of the slot about to be replaced
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[slot_ff] <= sample_ff;
      end
      rd_data_ff <= ring[slot_ff];
   end

endmodule : windowed_moving_average_top

`default_nettype wire

/* sv/wma_checker.sv */
// port-level checks for the windowed moving average block, bound to the top level
`default_nettype none

module wma_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic [wma_pkg::REQ_TDATA_W-1:0] req_tdata,
   input wire logic                            req_tuser,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [wma_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [wma_pkg::WINDOW_W-1:0]    csr_data,
   input wire logic                            csr_valid,
   input wire logic                            csr_ready
);
   import wma_pkg::*;

   // a stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // divisor is never zero nor beyond the largest window
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_FIELD_W-1:SAMPLE_W] != '0 &&
                     int'(rsp_tdata[RSP_FIELD_W-1:SAMPLE_W]) <= MAX_WINDOW)
      else $error("samples held out of range");

   // one request in flight: busy right after a request is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   // no response is valid right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

endmodule : wma_checker

bind windowed_moving_average_top wma_checker u_wma_checker (.*);

`default_nettype wire

/* dv/tb_top.sv */
// self-checking testbench for the windowed moving average block
`timescale 1ns / 100ps

module tb_top;
   import wma_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 1700;
   localparam int TAIL_ITEMS   = 150;
   localparam int DRAIN_CYCLES = 60;
   localparam int MAX_REPORTS  = 10;
   localparam int DIR_ROWS_N   = 28;

   typedef enum bit {
      ROW_CFG,
      ROW_SAMPLE
   } row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [SAMPLE_W-1:0] value;
      logic                restart;
      bit                  typed;
      logic [SAMPLE_W-1:0] average;
      logic [HELD_W-1:0]   held;
   } stim_row_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] average;
      logic [HELD_W-1:0]          held;
   } avg_result_type;

   // typed rows can be read straight off the window and the samples
   localparam stim_row_type DIR_ROWS [DIR_ROWS_N] = '{
      '{ROW_SAMPLE, 32'h7FFFFFFF, 1'b0, 1'b1, 32'h7FFFFFFF, 6'd1},
      '{ROW_SAMPLE, 32'h80000000, 1'b0, 1'b1, 32'h80000000, 6'd1},
      '{ROW_SAMPLE, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 6'd1},
      '{ROW_SAMPLE, 32'h00000000, 1'b0, 1'b1, 32'h00000000, 6'd1},
      '{ROW_CFG,    32'd0,        1'b0, 1'b0, 32'd0,        6'd0},
      '{ROW_SAMPLE, 32'h00000005, 1'b0, 1'b1, 32'h00000005, 6'd1},
      '{ROW_SAMPLE, 32'hFFFFFFF9, 1'b0, 1'b1, 32'hFFFFFFF9, 6'd1},
      '{ROW_CFG,    32'd2,        1'b0, 1'b0, 32'd0,        6'd0},
      '{ROW_SAMPLE, 32'h7FFFFFFF, 1'b0, 1'b1, 32'h7FFFFFFF, 6'd1},
      '{ROW_SAMPLE, 32'h7FFFFFFF, 1'b0, 1'b1, 32'h7FFFFFFF, 6'd2},
      '{ROW_SAMPLE, 32'h80000000, 1'b0, 1'b1, 32'h00000000, 6'd2},
      '{ROW_SAMPLE, 32'h80000000, 1'b0, 1'b1, 32'h80000000, 6'd2},
      '{ROW_SAMPLE, 32'h00000003, 1'b1, 1'b1, 32'h00000003, 6'd1},
      '{ROW_SAMPLE, 32'hFFFFFFFC, 1'b0, 1'b1, 32'h00000000, 6'd2},
      '{ROW_SAMPLE, 32'hFFFFFFFC, 1'b0, 1'b1, 32'hFFFFFFFC, 6'd2},
      '{ROW_CFG,    32'd3,        1'b0, 1'b0, 32'd0,        6'd0},
      '{ROW_SAMPLE, 32'h00000007, 1'b1, 1'b1, 32'h00000007, 6'd1},
      '{ROW_SAMPLE, 32'h00000008, 1'b0, 1'b1, 32'h00000007, 6'd2},
      '{ROW_CFG,    32'd3,        1'b0, 1'b0, 32'd0,        6'd0},
      '{ROW_SAMPLE, 32'h00000001, 1'b0, 1'b1, 32'h00000001, 6'd1},
      '{ROW_CFG,    32'd63,       1'b0, 1'b0, 32'd0,        6'd0},
      '{ROW_SAMPLE, 32'h80000000, 1'b0, 1'b0, 32'd0,        6'd0},
      '{ROW_SAMPLE, 32'h7FFFFFFF, 1'b0, 1'b0, 32'd0,        6'd0},
      '{ROW_SAMPLE, 32'h12345678, 1'b0, 1'b0, 32'd0,        6'd0},
      '{ROW_CFG,    32'd33,       1'b0, 1'b0, 32'd0,        6'd0},
      '{ROW_SAMPLE, 32'hAAAAAAAA, 1'b0, 1'b0, 32'd0,        6'd0},
      '{ROW_SAMPLE, 32'h55555555, 1'b0, 1'b0, 32'd0,        6'd0},
      '{ROW_SAMPLE, 32'h00000001, 1'b1, 1'b0, 32'd0,        6'd0}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [WINDOW_W-1:0]    csr_data   = '0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;

   // predictor state
   logic signed [SAMPLE_W-1:0] hist [MAX_WINDOW];
   longint                     hist_sum;
   int unsigned                next_slot;
   int unsigned                held_cnt;
   logic [WINDOW_W-1:0]        window_reg;

   avg_result_type expected_averages[$];
   int             mismatch_count;
   int             cycle_count;
   int             stall_left;
   bit             calm_stretch;
   bit             tail_phase;

   windowed_moving_average_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL windowed_moving_average_top");
         $finish;
      end
   end

   function automatic void clear_history();
      hist_sum  = 0;
      next_slot = 0;
      held_cnt  = 0;
   endfunction

   function automatic avg_result_type predict_average(input logic signed [SAMPLE_W-1:0] s,
                                                      input logic restart);
      int unsigned    win;
      int unsigned    slot;
      longint         quot;
      avg_result_type r;
      if (window_reg == 0)
         win = 1;
      else if (window_reg > MAX_WINDOW)
         win = MAX_WINDOW;
      else
         win = window_reg;
      if (restart)
         clear_history();
      slot = next_slot;
      if (slot >= win)
         slot = 0;
      // once the window is full the oldest sample drops out of the sum
      if (held_cnt >= win)
         hist_sum -= longint'(hist[slot]);
      else
         held_cnt++;
      hist[slot] = s;
      hist_sum  += longint'(s);
      slot++;
      if (slot >= win)
         slot = 0;
      next_slot = slot;
      quot      = hist_sum / longint'(held_cnt);
      r.average = quot[SAMPLE_W-1:0];
      r.held    = held_cnt[HELD_W-1:0];
      return r;
   endfunction

   task automatic wait_for_drain();
      while (expected_averages.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_W-1:0] value);
      @(negedge clock);
      csr_data  = value;
      csr_valid = 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      window_reg = value;
      clear_history();
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic restart,
                              input bit typed, input logic [SAMPLE_W-1:0] typed_avg,
                              input logic [HELD_W-1:0] typed_held);
      avg_result_type r;
      if (!tail_phase && !calm_stretch && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 17)) @(negedge clock);
      @(negedge clock);
      req_tdata  = value;
      req_tuser  = restart;
      req_tvalid = 1'b1;
      do
         @(posedge clock);
      while (!req_tready);
      r = predict_average(value, restart);
      if (typed) begin
         r.average = typed_avg;
         r.held    = typed_held;
      end
      expected_averages.push_back(r);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // response side back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else if (!tail_phase && !calm_stretch && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      avg_result_type got;
      avg_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.average = rsp_tdata[SAMPLE_W-1:0];
         got.held    = rsp_tdata[SAMPLE_W +: HELD_W];
         if (expected_averages.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: average %0d held %0d",
                        got.average, got.held);
         end else begin
            want = expected_averages.pop_front();
            if (got.average !== want.average || got.held !== want.held) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected average %0d held %0d, got average %0d held %0d",
                           want.average, want.held, got.average, got.held);
            end
         end
      end
   end

   initial begin
      int                  sent;
      int                  phase_len;
      logic [WINDOW_W-1:0] win_pick;
      logic [SAMPLE_W-1:0] s;

      window_reg     = WINDOW_W'(1);
      mismatch_count = 0;
      cycle_count    = 0;
      stall_left     = 0;
      calm_stretch   = 1'b0;
      tail_phase     = 1'b0;
      clear_history();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_ROWS_N; i++) begin
         if (DIR_ROWS[i].kind == ROW_CFG) begin
            wait_for_drain();
            write_window(DIR_ROWS[i].value[WINDOW_W-1:0]);
         end else begin
            send_sample(DIR_ROWS[i].value, DIR_ROWS[i].restart, DIR_ROWS[i].typed,
                        DIR_ROWS[i].average, DIR_ROWS[i].held);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // window writes only once every request has been answered
         wait_for_drain();
         case ($urandom_range(0, 9))
            0:       win_pick = WINDOW_W'(MAX_WINDOW);
            1:       win_pick = WINDOW_W'($urandom_range(MAX_WINDOW + 1, 63));
            2:       win_pick = '0;
            3, 4:    win_pick = WINDOW_W'($urandom_range(9, MAX_WINDOW - 1));
            default: win_pick = WINDOW_W'($urandom_range(1, 8));
         endcase
         write_window(win_pick);
         calm_stretch = ($urandom_range(0, 4) == 0);
         tail_phase   = (sent >= RANDOM_ITEMS - TAIL_ITEMS);
         phase_len    = $urandom_range(8, 120);
         for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            case ($urandom_range(0, 7))
               0:       s = 32'h7FFFFFFF;
               1:       s = 32'h80000000;
               2:       s = 32'($urandom_range(0, 32)) - 32'd16;
               3:       s = 32'h7FFFFFF0 + 32'($urandom_range(0, 15));
               4:       s = 32'h80000000 + 32'($urandom_range(0, 15));
               default: s = $urandom;
            endcase
            send_sample(s, $urandom_range(0, 19) == 0, 1'b0, '0, '0);
            sent++;
            if (sent >= RANDOM_ITEMS - TAIL_ITEMS)
               tail_phase = 1'b1;
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_averages.size() == 0)
         $display("PASS windowed_moving_average_top");
      else
         $display("FAIL windowed_moving_average_top");
      $finish;
   end

endmodule

/* windowed_moving_average_top.f */
sv/wma_pkg.sv
sv/windowed_moving_average_top.sv
sv/wma_checker.sv
dv/tb_top.sv
